/* sv/tpdt_pkg.sv */
// shared types for the triangle point depth test pipeline
package tpdt_pkg;

  // per-request status that travels beside the depth
  typedef struct packed {
    logic degenerate;
    logic in_triangle;
  } tpdt_flags_t;

endpackage

/* sv/tpdt_geom.sv */
// edge terms, barycentric numerators, sign normalisation and inside test
module tpdt_geom #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   in_x0,
  input  logic signed [W-1:0]   in_y0,
  input  logic signed [W-1:0]   in_z0,
  input  logic signed [W-1:0]   in_x1,
  input  logic signed [W-1:0]   in_y1,
  input  logic signed [W-1:0]   in_z1,
  input  logic signed [W-1:0]   in_x2,
  input  logic signed [W-1:0]   in_y2,
  input  logic signed [W-1:0]   in_z2,
  input  logic signed [W-1:0]   in_px,
  input  logic signed [W-1:0]   in_py,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [2*W+4:0] out_den,
  output logic signed [2*W+4:0] out_sn,
  output logic signed [2*W+4:0] out_rn,
  output logic signed [2*W+4:0] out_tn,
  output logic signed [W-1:0]   out_z0,
  output logic signed [W-1:0]   out_z1,
  output logic signed [W-1:0]   out_z2,
  output tpdt_pkg::tpdt_flags_t out_flags
);

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;
  localparam int NB = 2 * W + 5;
  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // stage 1: differences
  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r, px_r, py_r;
  logic signed [W-1:0]  z0_1_r, z1_1_r, z2_1_r;
  // stage 2: products
  logic signed [PW-1:0] ad_r, be_r, apx_r, bpy_r, cpx_r, dpy_r;
  logic signed [W-1:0]  z0_2_r, z1_2_r, z2_2_r;
  // stage 3: sums
  logic signed [SW-1:0] den_r, sn_r, rn_r;
  logic signed [W-1:0]  z0_3_r, z1_3_r, z2_3_r;
  // stage 4: third numerator
  logic signed [NB-1:0] den4_r, sn4_r, rn4_r, tn4_r;
  logic                 dneg_r, deg4_r;
  logic signed [W-1:0]  z0_4_r, z1_4_r, z2_4_r;
  // stage 5: normalised
  logic signed [NB-1:0] den5_r, sn5_r, rn5_r, tn5_r;
  logic signed [NB-1:0] den5_nxt, sn5_nxt, rn5_nxt, tn5_nxt;
  tpdt_pkg::tpdt_flags_t flags_r, flags_nxt;
  logic signed [W-1:0]  z0_5_r, z1_5_r, z2_5_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    if (dneg_r) begin
      den5_nxt = -den4_r;
      sn5_nxt  = -sn4_r;
      rn5_nxt  = -rn4_r;
      tn5_nxt  = -tn4_r;
    end else begin
      den5_nxt = den4_r;
      sn5_nxt  = sn4_r;
      rn5_nxt  = rn4_r;
      tn5_nxt  = tn4_r;
    end
    flags_nxt.degenerate  = deg4_r;
    flags_nxt.in_triangle = !deg4_r
        && !sn5_nxt[NB-1] && (sn5_nxt <= den5_nxt)
        && !rn5_nxt[NB-1] && (rn5_nxt <= den5_nxt)
        && !tn5_nxt[NB-1] && (tn5_nxt <= den5_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r    <= DW'(in_y1) - DW'(in_y2);
      b_r    <= DW'(in_x2) - DW'(in_x1);
      c_r    <= DW'(in_y2) - DW'(in_y0);
      d_r    <= DW'(in_x0) - DW'(in_x2);
      e_r    <= DW'(in_y0) - DW'(in_y2);
      px_r   <= DW'(in_px) - DW'(in_x2);
      py_r   <= DW'(in_py) - DW'(in_y2);
      z0_1_r <= in_z0;
      z1_1_r <= in_z1;
      z2_1_r <= in_z2;
    end
    if (en[1]) begin
      ad_r   <= PW'(a_r) * PW'(d_r);
      be_r   <= PW'(b_r) * PW'(e_r);
      apx_r  <= PW'(a_r) * PW'(px_r);
      bpy_r  <= PW'(b_r) * PW'(py_r);
      cpx_r  <= PW'(c_r) * PW'(px_r);
      dpy_r  <= PW'(d_r) * PW'(py_r);
      z0_2_r <= z0_1_r;
      z1_2_r <= z1_1_r;
      z2_2_r <= z2_1_r;
    end
    if (en[2]) begin
      den_r  <= SW'(ad_r) + SW'(be_r);
      sn_r   <= SW'(apx_r) + SW'(bpy_r);
      rn_r   <= SW'(cpx_r) + SW'(dpy_r);
      z0_3_r <= z0_2_r;
      z1_3_r <= z1_2_r;
      z2_3_r <= z2_2_r;
    end
    if (en[3]) begin
      den4_r <= NB'(den_r);
      sn4_r  <= NB'(sn_r);
      rn4_r  <= NB'(rn_r);
      tn4_r  <= NB'(den_r) - NB'(sn_r) - NB'(rn_r);
      dneg_r <= den_r[SW-1];
      deg4_r <= (den_r == '0);
      z0_4_r <= z0_3_r;
      z1_4_r <= z1_3_r;
      z2_4_r <= z2_3_r;
    end
    if (en[4]) begin
      den5_r  <= den5_nxt;
      sn5_r   <= sn5_nxt;
      rn5_r   <= rn5_nxt;
      tn5_r   <= tn5_nxt;
      flags_r <= flags_nxt;
      z0_5_r  <= z0_4_r;
      z1_5_r  <= z1_4_r;
      z2_5_r  <= z2_4_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_den   = den5_r;
  assign out_sn    = sn5_r;
  assign out_rn    = rn5_r;
  assign out_tn    = tn5_r;
  assign out_z0    = z0_5_r;
  assign out_z1    = z1_5_r;
  assign out_z2    = z2_5_r;
  assign out_flags = flags_r;

endmodule

/* sv/tpdt_interp.sv */
// weighted depth numerator, its magnitude and the quotient range check
module tpdt_interp #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [2*W+4:0] in_den,
  input  logic signed [2*W+4:0] in_sn,
  input  logic signed [2*W+4:0] in_rn,
  input  logic signed [2*W+4:0] in_tn,
  input  logic signed [W-1:0]   in_z0,
  input  logic signed [W-1:0]   in_z1,
  input  logic signed [W-1:0]   in_z2,
  input  tpdt_pkg::tpdt_flags_t in_flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3*W+6:0]        out_mag,
  output logic [3*W+6:0]        out_den,
  output logic                  out_neg,
  output logic                  out_ovf,
  output tpdt_pkg::tpdt_flags_t out_flags
);

  localparam int NB = 2 * W + 5;
  localparam int MW = NB + W;
  localparam int MB = 3 * W + 7;
  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  logic signed [MW-1:0] m0_r, m1_r, m2_r;
  logic signed [NB-1:0] den1_r, den2_r;
  tpdt_pkg::tpdt_flags_t fl1_r, fl2_r, fl3_r;
  logic signed [MB-1:0] num_r;
  logic [MB-1:0]        mag_r, mag_nxt, den3_r;
  logic                 neg_r, ovf_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign mag_nxt = num_r[MB-1] ? MB'(-num_r) : MB'(num_r);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m0_r   <= MW'(in_sn) * MW'(in_z0);
      m1_r   <= MW'(in_rn) * MW'(in_z1);
      m2_r   <= MW'(in_tn) * MW'(in_z2);
      den1_r <= in_den;
      fl1_r  <= in_flags;
    end
    if (en[1]) begin
      num_r  <= MB'(m0_r) + MB'(m1_r) + MB'(m2_r);
      den2_r <= den1_r;
      fl2_r  <= fl1_r;
    end
    if (en[2]) begin
      mag_r  <= mag_nxt;
      neg_r  <= num_r[MB-1];
      // quotient magnitude reaches 2^W or more: saturates either way
      ovf_r  <= mag_nxt >= (MB'(unsigned'(den2_r)) << W);
      den3_r <= MB'(unsigned'(den2_r));
      fl3_r  <= fl2_r;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_mag   = mag_r;
  assign out_den   = den3_r;
  assign out_neg   = neg_r;
  assign out_ovf   = ovf_r;
  assign out_flags = fl3_r;

endmodule

/* sv/tpdt_div.sv */
// restoring divider, one quotient bit per stage, then sign and saturation
module tpdt_div #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3*W+6:0]        in_mag,
  input  logic [3*W+6:0]        in_den,
  input  logic                  in_neg,
  input  logic                  in_ovf,
  input  tpdt_pkg::tpdt_flags_t in_flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [W-1:0]   out_depth,
  output tpdt_pkg::tpdt_flags_t out_flags
);

  localparam int MB = 3 * W + 7;
  localparam int NS = W + 1;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  logic [MB-1:0] rem_r [W];
  logic [MB-1:0] den_r [W];
  logic [W-1:0]  q_r   [W];
  logic          neg_r [W];
  logic          ovf_r [W];
  tpdt_pkg::tpdt_flags_t fl_r [W];

  logic [W-1:0]          qm;
  logic signed [W-1:0]   depth_r, depth_nxt;
  tpdt_pkg::tpdt_flags_t flo_r;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    localparam int BIT = W - 1 - k;
    logic [MB-1:0] rem_in, den_in, shd;
    logic [W-1:0]  q_in;
    logic          neg_in, ovf_in;
    tpdt_pkg::tpdt_flags_t fl_in;

    if (k == 0) begin : g_first
      assign rem_in = in_mag;
      assign den_in = in_den;
      assign q_in   = '0;
      assign neg_in = in_neg;
      assign ovf_in = in_ovf;
      assign fl_in  = in_flags;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign neg_in = neg_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign fl_in  = fl_r[k-1];
    end

    assign shd = den_in << BIT;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (rem_in >= shd) begin
          rem_r[k] <= rem_in - shd;
          q_r[k]   <= q_in | (W'(1) << BIT);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
        ovf_r[k] <= ovf_in;
        fl_r[k]  <= fl_in;
      end
    end
  end

  assign qm = q_r[W-1];

  always_comb begin
    if (fl_r[W-1].degenerate) begin
      depth_nxt = '0;
    end else if (!neg_r[W-1]) begin
      if (ovf_r[W-1] || qm[W-1]) begin
        depth_nxt = {1'b0, {(W-1){1'b1}}};
      end else begin
        depth_nxt = qm;
      end
    end else begin
      if (ovf_r[W-1] || (qm > {1'b1, {(W-1){1'b0}}})) begin
        depth_nxt = {1'b1, {(W-1){1'b0}}};
      end else begin
        depth_nxt = -qm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      depth_r <= depth_nxt;
      flo_r   <= fl_r[W-1];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_depth = depth_r;
  assign out_flags = flo_r;

endmodule

/* sv/triangle_point_depth_test_unit.sv */
// top level of the triangle point depth test pipeline
//
//  channel | direction | tdata                                  | tuser
//  in_     | slave     | v0_x v0_y v0_z v1_x v1_y v1_z v2_x ... | none
//  out_    | master    | depth                                  | in_triangle, degenerate
//
// one request enters per cycle while the output is not stalled; the pipeline has
// 5 geometry stages, 3 depth numerator stages, COORD_BITS divider stages and
// one output register; the divider's one-bit-per-stage chain sets the depth
// rst_n clears only the stage valid bits, payload is left as it is
// each stage holds its request while the next one is full and not moving,
// so bubbles close up under a stall and nothing is lost or repeated
module triangle_point_depth_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, pt_x, pt_y, zero fill
  input  logic [((11*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // depth, zero fill
  output logic [((COORD_BITS+7)/8)*8-1:0]    out_tdata,
  // in_triangle, degenerate
  output logic [1:0]          out_tuser
);

  localparam int W   = COORD_BITS;
  localparam int NB  = 2 * W + 5;
  localparam int MB  = 3 * W + 7;
  localparam int OTW = ((W + 7) / 8) * 8;

  // geometry to interpolation
  logic                  g_valid, g_ready;
  logic signed [NB-1:0]  g_den, g_sn, g_rn, g_tn;
  logic signed [W-1:0]   g_z0, g_z1, g_z2;
  tpdt_pkg::tpdt_flags_t g_flags;

  // interpolation to divider
  logic                  i_valid, i_ready;
  logic [MB-1:0]         i_mag, i_den;
  logic                  i_neg, i_ovf;
  tpdt_pkg::tpdt_flags_t i_flags;

  logic signed [W-1:0]   depth;
  tpdt_pkg::tpdt_flags_t o_flags;

  tpdt_geom #(.W(W)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x0     (in_tdata[0*W +: W]),
    .in_y0     (in_tdata[1*W +: W]),
    .in_z0     (in_tdata[2*W +: W]),
    .in_x1     (in_tdata[3*W +: W]),
    .in_y1     (in_tdata[4*W +: W]),
    .in_z1     (in_tdata[5*W +: W]),
    .in_x2     (in_tdata[6*W +: W]),
    .in_y2     (in_tdata[7*W +: W]),
    .in_z2     (in_tdata[8*W +: W]),
    .in_px     (in_tdata[9*W +: W]),
    .in_py     (in_tdata[10*W +: W]),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_den   (g_den),
    .out_sn    (g_sn),
    .out_rn    (g_rn),
    .out_tn    (g_tn),
    .out_z0    (g_z0),
    .out_z1    (g_z1),
    .out_z2    (g_z2),
    .out_flags (g_flags)
  );

  tpdt_interp #(.W(W)) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_den    (g_den),
    .in_sn     (g_sn),
    .in_rn     (g_rn),
    .in_tn     (g_tn),
    .in_z0     (g_z0),
    .in_z1     (g_z1),
    .in_z2     (g_z2),
    .in_flags  (g_flags),
    .out_valid (i_valid),
    .out_ready (i_ready),
    .out_mag   (i_mag),
    .out_den   (i_den),
    .out_neg   (i_neg),
    .out_ovf   (i_ovf),
    .out_flags (i_flags)
  );

  tpdt_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (i_valid),
    .in_ready  (i_ready),
    .in_mag    (i_mag),
    .in_den    (i_den),
    .in_neg    (i_neg),
    .in_ovf    (i_ovf),
    .in_flags  (i_flags),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_depth (depth),
    .out_flags (o_flags)
  );

  // depth is sign-free in the padding: zero fill above it
  assign out_tdata = OTW'(unsigned'(depth));
  assign out_tuser = {o_flags.degenerate, o_flags.in_triangle};

endmodule

/* sv/tpdt_checker.sv */
// port-level checks for the triangle point depth test unit, with its bind
module tpdt_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((COORD_BITS+7)/8)*8-1:0]     out_tdata,
  input logic [1:0]                          out_tuser
);

  // a degenerate triangle never reports inside and always a zero depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && (out_tdata == '0))
    else $error("degenerate result with inside flag or nonzero depth");

  // pipeline is empty straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result keeps its depth and flags
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  // padding above depth is sign-free zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >> COORD_BITS) == '0))
    else $error("depth padding not zero");

endmodule

bind triangle_point_depth_test_unit tpdt_checker #(.COORD_BITS(COORD_BITS)) u_tpdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
